[design/tentative_landmark_table_macros.svh]
// assertion macros used by the port checker
`ifndef TENTATIVE_LANDMARK_TABLE_MACROS_SVH
`define TENTATIVE_LANDMARK_TABLE_MACROS_SVH

// property checked outside reset
`define TLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define TLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/tlt_pkg.sv]
// constants and register codes for the tentative landmark table
`default_nettype none
package tlt_pkg;
    localparam int CAPACITY_DEF   = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int DIST_W   = 33;
    localparam int CNT_W    = 8;
    localparam int RATE_W   = 9;
    localparam int RADIUS_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_DIST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE   = 2'd3;

    localparam logic [DIST_W-1:0] MATCH_DIST_RST = 33'd10486;
    localparam logic [DIST_W-1:0] NEW_DIST_RST   = 33'd262144;
    localparam logic [CNT_W-1:0]  MAX_TRIES_RST  = 8'd10;
    localparam logic [RATE_W-1:0] MIN_RATE_RST   = 9'd128;
    localparam logic [CNT_W-1:0]  CNT_MAX        = 8'd255;
endpackage
`default_nettype wire

[design/tentative_landmark_table.sv]
// tentative landmark table: candidate store with hit/miss finalisation
//
//  channel  | dir | beat contents
//  s_axis   | in  | tdata: det_x, det_y, det_radius; tuser: kind
//  m_axis   | out | tdata: lm_x, lm_y, lm_radius; tuser: found, overflow; tlast: last
//  cfg      | in  | we, idx, data: one register write per cycle
//
// one beat at a time; the table lives in a single memory read one entry per step
// detection: each entry is read, loaded, squared and compared; a matching entry then goes
//   through the bit-serial running-mean divider and a write-back; a final step may add a new entry
// end of scan: each entry is read, loaded and acted on; emitting waits while the result register is stalled
// synchronous active-low reset empties the table and clears the overflow flag
`default_nettype none
module tentative_landmark_table
    import tlt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W  = ((2 * COORD_BITS + RADIUS_W + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + RADIUS_W + 7) / 8) * 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    input  wire  [IN_W-1:0]       i_s_tdata,   // det_x, det_y, det_radius
    input  wire                   i_s_tuser,   // kind
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata,   // lm_x, lm_y, lm_radius
    output logic [1:0]            o_m_tuser,   // found, overflow
    output logic                  o_m_tlast,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int NUM_W = COORD_BITS + 10;
    localparam int DEN_W = CNT_W + 1;
    localparam int SQ_W  = 2 * (COORD_BITS + 1);
    localparam int DS_W  = SQ_W + 1;
    localparam int CMP_W = (DS_W > DIST_W) ? DS_W : DIST_W;
    localparam int DC_W  = $clog2(NUM_W + 1);
    localparam int PR_W  = RATE_W + DEN_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_DLD  = 4'd2;
    localparam logic [3:0] S_DSQ  = 4'd3;
    localparam logic [3:0] S_DCMP = 4'd4;
    localparam logic [3:0] S_DDIV = 4'd5;
    localparam logic [3:0] S_DWB  = 4'd6;
    localparam logic [3:0] S_DNEW = 4'd7;
    localparam logic [3:0] S_ELD  = 4'd8;
    localparam logic [3:0] S_EACT = 4'd9;
    localparam logic [3:0] S_EEND = 4'd10;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [RADIUS_W-1:0]          r;
        logic [CNT_W-1:0]             hits;
        logic [CNT_W-1:0]             misses;
        logic                         seen;
    } t_entry;

    // table memory
    t_entry r_mem [CAPACITY];
    t_entry r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_entry        mem_wd;

    // configuration
    logic [DIST_W-1:0] r_match_dist, r_new_dist;
    logic [CNT_W-1:0]  r_max_tries;
    logic [RATE_W-1:0] r_min_rate;

    // control
    logic [3:0]    r_state;
    logic          r_kind;
    logic [CW-1:0] r_k, r_keep, r_used;
    logic          r_ovf, r_matched, r_any;
    logic [DS_W-1:0] r_near;

    // current beat and entry
    logic signed [COORD_BITS-1:0] r_det_x, r_det_y;
    logic [RADIUS_W-1:0]          r_det_r;
    t_entry r_ent;

    // distance and mean datapath
    logic [COORD_BITS:0] r_adx, r_ady;
    logic [SQ_W-1:0]     r_sqx, r_sqy;
    logic                r_negx, r_negy;
    logic [NUM_W-1:0]    r_magx, r_magy, r_qx, r_qy;
    logic [DEN_W-1:0]    r_remx, r_remy, r_den;
    logic [DC_W-1:0]     r_dcnt;
    logic                r_fin, r_emit;

    // pending landmark and result register
    logic   r_pv;
    t_entry r_pend;
    logic   r_ov, r_ofound, r_olast, r_oovf;
    logic signed [COORD_BITS-1:0] r_ox, r_oy;
    logic [RADIUS_W-1:0] r_or;

    // combinational helpers
    logic signed [COORD_BITS:0] ddx, ddy;
    logic signed [NUM_W:0]      prx, pry, nx, ny;
    logic [DS_W-1:0]  dsum;
    logic             dmatch;
    logic [DEN_W:0]   tx, ty;
    logic             gex, gey;
    logic signed [COORD_BITS-1:0] qx_s, qy_s;
    logic [CNT_W-1:0] mi;
    logic [DEN_W-1:0] tries;
    logic [PR_W-1:0]  rate_prod;
    logic             out_free, last_k, do_new, out_load;
    logic [CW-1:0]    k_nxt;

    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_ov || i_m_tready;
    assign k_nxt      = r_k + CW'(1);
    assign last_k     = (k_nxt == r_used);
    assign out_load   = out_free && (((r_state == S_EACT) && r_fin && r_emit && r_pv) ||
                                     (r_state == S_EEND));

    always_comb begin
        ddx  = r_rdata.x - r_det_x;
        ddy  = r_rdata.y - r_det_y;
        prx  = $signed({1'b0, r_rdata.hits}) * r_rdata.x;
        pry  = $signed({1'b0, r_rdata.hits}) * r_rdata.y;
        nx   = prx + r_det_x;
        ny   = pry + r_det_y;
        dsum = DS_W'(r_sqx) + DS_W'(r_sqy);
        dmatch = CMP_W'(dsum) < CMP_W'(r_match_dist);
        tx   = {r_remx, r_magx[NUM_W-1]};
        ty   = {r_remy, r_magy[NUM_W-1]};
        gex  = tx >= {1'b0, r_den};
        gey  = ty >= {1'b0, r_den};
        qx_s = r_negx ? -$signed(r_qx[COORD_BITS-1:0]) : $signed(r_qx[COORD_BITS-1:0]);
        qy_s = r_negy ? -$signed(r_qy[COORD_BITS-1:0]) : $signed(r_qy[COORD_BITS-1:0]);
        mi   = (!r_rdata.seen && r_rdata.misses != CNT_MAX) ?
               r_rdata.misses + CNT_W'(1) : r_rdata.misses;
        tries = {1'b0, r_rdata.hits} + {1'b0, mi};
        rate_prod = r_min_rate * tries;
        do_new = !r_matched && (!r_any || CMP_W'(r_near) > CMP_W'(r_new_dist));
    end

    // memory write port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_k[AW-1:0];
        mem_wd = r_ent;
        unique case (r_state)
            S_DWB: begin
                mem_we      = 1'b1;
                mem_wd.x    = qx_s;
                mem_wd.y    = qy_s;
                mem_wd.hits = (r_ent.hits == CNT_MAX) ? CNT_MAX : r_ent.hits + CNT_W'(1);
                mem_wd.seen = 1'b1;
            end
            S_DNEW: begin
                mem_we = do_new && (r_used < CW'(CAPACITY));
                mem_wa = r_used[AW-1:0];
                mem_wd = '{x: r_det_x, y: r_det_y, r: r_det_r, hits: CNT_W'(1),
                           misses: '0, seen: 1'b1};
            end
            S_EACT: begin
                mem_we = !r_fin;
                mem_wa = r_keep[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[r_k[AW-1:0]];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_dist <= MATCH_DIST_RST;
            r_new_dist   <= NEW_DIST_RST;
            r_max_tries  <= MAX_TRIES_RST;
            r_min_rate   <= MIN_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATCH_DIST: r_match_dist <= i_cfg_data[DIST_W-1:0];
                CFG_NEW_DIST:   r_new_dist   <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_TRIES:  r_max_tries  <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_RATE:   r_min_rate   <= i_cfg_data[RATE_W-1:0];
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            if (out_load)        r_ov <= 1'b1;
            else if (i_m_tready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind    <= i_s_tuser;
                        r_det_x   <= i_s_tdata[COORD_BITS-1:0];
                        r_det_y   <= i_s_tdata[2*COORD_BITS-1:COORD_BITS];
                        r_det_r   <= i_s_tdata[2*COORD_BITS+RADIUS_W-1:2*COORD_BITS];
                        r_k       <= '0;
                        r_keep    <= '0;
                        r_matched <= 1'b0;
                        r_any     <= 1'b0;
                        r_pv      <= 1'b0;
                        if (r_used == '0) r_state <= i_s_tuser ? S_EEND : S_DNEW;
                        else              r_state <= S_RD;
                    end
                end
                S_RD: r_state <= r_kind ? S_ELD : S_DLD;
                S_DLD: begin
                    r_ent  <= r_rdata;
                    r_adx  <= ddx[COORD_BITS] ? (COORD_BITS+1)'(-ddx) : (COORD_BITS+1)'(ddx);
                    r_ady  <= ddy[COORD_BITS] ? (COORD_BITS+1)'(-ddy) : (COORD_BITS+1)'(ddy);
                    r_negx <= nx[NUM_W];
                    r_negy <= ny[NUM_W];
                    r_magx <= nx[NUM_W] ? NUM_W'(-nx) : NUM_W'(nx);
                    r_magy <= ny[NUM_W] ? NUM_W'(-ny) : NUM_W'(ny);
                    r_den  <= {1'b0, r_rdata.hits} + DEN_W'(1);
                    r_state <= S_DSQ;
                end
                S_DSQ: begin
                    r_sqx   <= r_adx * r_adx;
                    r_sqy   <= r_ady * r_ady;
                    r_state <= S_DCMP;
                end
                S_DCMP: begin
                    if (dmatch) begin
                        r_matched <= 1'b1;
                        // round half away from zero on the magnitude
                        r_magx  <= r_magx + NUM_W'(r_den >> 1);
                        r_magy  <= r_magy + NUM_W'(r_den >> 1);
                        r_remx  <= '0;
                        r_remy  <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DDIV;
                    end else begin
                        if (!r_any || dsum < r_near) r_near <= dsum;
                        r_any   <= 1'b1;
                        r_k     <= k_nxt;
                        r_state <= last_k ? S_DNEW : S_RD;
                    end
                end
                S_DDIV: begin
                    r_remx <= gex ? DEN_W'(tx - {1'b0, r_den}) : tx[DEN_W-1:0];
                    r_remy <= gey ? DEN_W'(ty - {1'b0, r_den}) : ty[DEN_W-1:0];
                    r_magx <= r_magx << 1;
                    r_magy <= r_magy << 1;
                    r_qx   <= {r_qx[NUM_W-2:0], gex};
                    r_qy   <= {r_qy[NUM_W-2:0], gey};
                    r_dcnt <= r_dcnt + DC_W'(1);
                    if (r_dcnt == DC_W'(NUM_W - 1)) r_state <= S_DWB;
                end
                S_DWB: begin
                    r_k     <= k_nxt;
                    r_state <= last_k ? S_DNEW : S_RD;
                end
                S_DNEW: begin
                    if (do_new) begin
                        if (r_used < CW'(CAPACITY)) r_used <= r_used + CW'(1);
                        else                        r_ovf  <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_ELD: begin
                    r_ent  <= '{x: r_rdata.x, y: r_rdata.y, r: r_rdata.r,
                                hits: r_rdata.hits, misses: mi, seen: 1'b0};
                    r_fin  <= tries >= {1'b0, r_max_tries};
                    r_emit <= PR_W'({r_rdata.hits, 8'd0}) > rate_prod;
                    r_state <= S_EACT;
                end
                S_EACT: begin
                    if (!(r_fin && r_emit && r_pv && !out_free)) begin
                        if (r_fin && r_emit) begin
                            if (r_pv) begin
                                r_ox     <= r_pend.x;
                                r_oy     <= r_pend.y;
                                r_or     <= r_pend.r;
                                r_ofound <= 1'b1;
                                r_olast  <= 1'b0;
                                r_oovf   <= r_ovf;
                            end
                            r_pend <= r_ent;
                            r_pv   <= 1'b1;
                        end
                        if (!r_fin) r_keep <= r_keep + CW'(1);
                        r_k     <= k_nxt;
                        r_state <= last_k ? S_EEND : S_RD;
                    end
                end
                S_EEND: begin
                    if (out_free) begin
                        // final beat, or the empty marker when nothing was emitted
                        r_ox     <= r_pv ? r_pend.x : '0;
                        r_oy     <= r_pv ? r_pend.y : '0;
                        r_or     <= r_pv ? r_pend.r : '0;
                        r_ofound <= r_pv;
                        r_olast  <= 1'b1;
                        r_oovf   <= r_ovf;
                        r_used   <= r_keep;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = OUT_W'({r_or, r_oy, r_ox});
    assign o_m_tuser  = {r_oovf, r_ofound};
    assign o_m_tlast  = r_olast;
endmodule
`default_nettype wire

[design/tlt_checker.sv]
// port checker for the tentative landmark table, bound to the top level
`default_nettype none
`include "tentative_landmark_table_macros.svh"
module tlt_checker #(
    parameter int OUT_W = 48
) (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_s_tvalid,
    input wire             o_s_tready,
    input wire             o_m_tvalid,
    input wire             i_m_tready,
    input wire [OUT_W-1:0] o_m_tdata,
    input wire [1:0]       o_m_tuser,
    input wire             o_m_tlast
);
    // a result beat holds while stalled
    `TLT_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)), "result beat changed under stall")
    // one beat at a time: ready drops after an accepted beat
    `TLT_ASSERT(a_one_beat, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "second beat taken while busy")
    // the empty marker closes the scan and carries no landmark
    `TLT_ASSERT(a_marker, i_clk, i_rst_n, (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tlast && o_m_tdata == '0), "malformed empty marker")
    // nothing is offered straight after reset
    `TLT_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")
endmodule

bind tentative_landmark_table tlt_checker #(.OUT_W(OUT_W)) u_tlt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

[dv/tentative_landmark_table_chk.sv]
// checker for the tentative landmark table: watches all three channels and compares results
`timescale 1ns / 100ps
module tentative_landmark_table_chk
    import tlt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [47:0] i_s_tdata,
    input  wire         i_s_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [47:0] i_m_tdata,
    input  wire  [1:0]  i_m_tuser,
    input  wire         i_m_tlast,
    input  wire         i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_landmarks,
    output int          o_markers
);
    typedef struct packed {
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] lr;
        logic        found;
        logic        last;
        logic        ovf;
    } landmark_t;

    landmark_t lm_queue[$];

    logic signed [15:0] tab_x [16];
    logic signed [15:0] tab_y [16];
    logic [15:0] tab_r [16];
    int unsigned tab_hit [16];
    int unsigned tab_miss [16];
    bit tab_seen [16];
    int unsigned used;
    bit ovf_flag;

    logic [32:0] match_sq, new_sq;
    int unsigned tries_max, rate_min;

    function automatic longint mean_round(longint old, longint add, longint hits);
        longint num, den;
        num = hits * old + add;
        den = hits + 1;
        if (num >= 0) return (num + den / 2) / den;
        return -(((-num) + den / 2) / den);
    endfunction

    task automatic apply_detection(logic signed [15:0] x, logic signed [15:0] y,
                                   logic [15:0] r);
        bit hit_any, near_any;
        longint unsigned nearest, d, dx, dy;
        hit_any = 0; near_any = 0; nearest = 0;
        for (int k = 0; k < used; k++) begin
            dx = (tab_x[k] >= x) ? longint'(tab_x[k]) - x : longint'(x) - tab_x[k];
            dy = (tab_y[k] >= y) ? longint'(tab_y[k]) - y : longint'(y) - tab_y[k];
            d = dx * dx + dy * dy;
            if (d < match_sq) begin
                tab_x[k] = 16'(mean_round(tab_x[k], x, tab_hit[k]));
                tab_y[k] = 16'(mean_round(tab_y[k], y, tab_hit[k]));
                if (tab_hit[k] < 255) tab_hit[k]++;
                tab_seen[k] = 1;
                hit_any = 1;
            end else if (!near_any || d < nearest) begin
                nearest = d;
                near_any = 1;
            end
        end
        if (hit_any || (near_any && nearest <= new_sq)) return;
        if (used >= 16) begin
            ovf_flag = 1;
            return;
        end
        tab_x[used] = x; tab_y[used] = y; tab_r[used] = r;
        tab_hit[used] = 1; tab_miss[used] = 0; tab_seen[used] = 1;
        used++;
    endtask

    task automatic apply_end_of_scan();
        int unsigned keep, n, tries;
        landmark_t lm;
        keep = 0; n = 0;
        for (int k = 0; k < used; k++) begin
            if (!tab_seen[k] && tab_miss[k] < 255) tab_miss[k]++;
            tab_seen[k] = 0;
            tries = tab_hit[k] + tab_miss[k];
            if (tries >= tries_max) begin
                if (longint'(tab_hit[k]) * 256 > longint'(rate_min) * tries) begin
                    lm = '{tab_x[k], tab_y[k], tab_r[k], 1'b1, 1'b0, ovf_flag};
                    lm_queue = {lm_queue, lm};
                    n++;
                end
            end else begin
                tab_x[keep] = tab_x[k]; tab_y[keep] = tab_y[k]; tab_r[keep] = tab_r[k];
                tab_hit[keep] = tab_hit[k]; tab_miss[keep] = tab_miss[k];
                tab_seen[keep] = tab_seen[k];
                keep++;
            end
        end
        used = keep;
        if (n == 0) begin
            lm = '{16'd0, 16'd0, 16'd0, 1'b0, 1'b1, ovf_flag};
            lm_queue = {lm_queue, lm};
        end else begin
            lm_queue[lm_queue.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        landmark_t got, want;
        if (!i_rst_n) begin
            used <= 0;
            ovf_flag <= 0;
            match_sq <= MATCH_DIST_RST;
            new_sq <= NEW_DIST_RST;
            tries_max <= MAX_TRIES_RST;
            rate_min <= MIN_RATE_RST;
            o_errors <= 0;
            o_pending <= 0;
            o_landmarks <= 0;
            o_markers <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MATCH_DIST: match_sq = i_cfg_data;
                    CFG_NEW_DIST:   new_sq = i_cfg_data;
                    CFG_MAX_TRIES:  tries_max = i_cfg_data[7:0];
                    CFG_MIN_RATE:   rate_min = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser) apply_end_of_scan();
                else apply_detection(i_s_tdata[15:0], i_s_tdata[31:16], i_s_tdata[47:32]);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tdata[15:0], i_m_tdata[31:16], i_m_tdata[47:32],
                        i_m_tuser[0], i_m_tlast, i_m_tuser[1]};
                if (got.found) o_landmarks <= o_landmarks + 1;
                else o_markers <= o_markers + 1;
                if (lm_queue.size() == 0) begin
                    if (o_errors < 10) $display("unexpected beat: %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = lm_queue.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= lm_queue.size();
        end
    end
endmodule

[dv/tentative_landmark_table_tb.sv]
// testbench top for the tentative landmark table: stimulus, configuration and verdict
`timescale 1ns / 100ps
module tentative_landmark_table_tb;
    import tlt_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [47:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_MATCH_DIST;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int errors, pending, landmarks, markers;
    int quiet_cycles = 0;
    int sent = 0;
    int stall_mode = 0;

    localparam int WATCHDOG = 20000;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    tentative_landmark_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser), .o_m_tlast(m_tlast),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    tentative_landmark_table_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending),
        .o_landmarks(landmarks), .o_markers(markers)
    );

    // receiver stall pattern: phases of always ready, random, and mostly stalled
    always @(posedge i_clk) begin
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_beat(bit eos, logic [15:0] x, logic [15:0] y, logic [15:0] r);
        s_tvalid <= 1'b1;
        s_tuser <= eos;
        s_tdata <= {r, y, x};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic gap();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // one scan of detections, mostly near up to four anchor points, then end of scan
    task automatic random_scan(int spread, int width);
        logic [15:0] ax [4];
        logic [15:0] ay [4];
        int na, nd, burst, k;
        na = $urandom_range(1, 4);
        for (int i = 0; i < na; i++) begin
            ax[i] = 16'($urandom);
            ay[i] = 16'($urandom);
        end
        nd = $urandom_range(0, 6);
        burst = $urandom_range(1, 5);
        for (int i = 0; i < nd; i++) begin
            k = $urandom_range(0, na - 1);
            if ($urandom_range(0, 7) == 0)
                send_beat(0, 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_beat(0, 16'(ax[k] + $urandom_range(0, spread) - width),
                          16'(ay[k] + $urandom_range(0, spread) - width), 16'($urandom));
            if (--burst == 0) begin
                gap();
                burst = $urandom_range(1, 5);
            end
        end
        send_beat(1, 16'($urandom), 16'($urandom), 16'($urandom));
        gap();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, repeat hits, table overflow, ties in the mean
        write_reg(CFG_MAX_TRIES, 33'd2);
        send_beat(0, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_beat(0, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_beat(0, 16'h8000, 16'h8000, 16'h1234);
        send_beat(0, 16'h8001, 16'h8000, 16'h0001);
        send_beat(0, 16'h0000, 16'h0000, 16'h0000);
        send_beat(0, 16'hFFFF, 16'h0001, 16'h00FF);
        send_beat(1, 0, 0, 0);
        send_beat(1, 0, 0, 0);
        settle();
        write_reg(CFG_NEW_DIST, 33'd0);
        write_reg(CFG_MATCH_DIST, 33'd0);
        for (int i = 0; i < 17; i++) send_beat(0, 16'(i * 3000), 16'(-i * 50), 16'(i));
        send_beat(1, 0, 0, 0);
        send_beat(1, 0, 0, 0);
        settle();

        // random phases through several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_MATCH_DIST, MATCH_DIST_RST);
                    write_reg(CFG_NEW_DIST, NEW_DIST_RST);
                    write_reg(CFG_MAX_TRIES, 33'd3);
                    write_reg(CFG_MIN_RATE, 33'd128);
                end
                1: begin
                    write_reg(CFG_MATCH_DIST, 33'h1FFFFFFFF);
                    write_reg(CFG_MAX_TRIES, 33'd1);
                    write_reg(CFG_MIN_RATE, 33'd0);
                end
                2: begin
                    write_reg(CFG_MATCH_DIST, 33'd500);
                    write_reg(CFG_NEW_DIST, 33'h1FFFFFFFF);
                    write_reg(CFG_MAX_TRIES, 33'd0);
                    write_reg(CFG_MIN_RATE, 33'd256);
                end
                3: begin
                    write_reg(CFG_MATCH_DIST, 33'd2000);
                    write_reg(CFG_NEW_DIST, 33'd100);
                    write_reg(CFG_MAX_TRIES, 33'd255);
                    write_reg(CFG_MIN_RATE, 33'd511);
                end
                4: begin
                    write_reg(CFG_MAX_TRIES, 33'd4);
                    write_reg(CFG_MIN_RATE, 33'd64);
                end
                default: begin
                    write_reg(CFG_MATCH_DIST, MATCH_DIST_RST);
                    write_reg(CFG_NEW_DIST, NEW_DIST_RST);
                    write_reg(CFG_MAX_TRIES, CFG_DATA_W'(MAX_TRIES_RST));
                    write_reg(CFG_MIN_RATE, CFG_DATA_W'(MIN_RATE_RST));
                end
            endcase
            for (int s = 0; s < 8; s++) random_scan(ph == 1 ? 65535 : 120, 60);
            settle();
        end

        $display("beats sent %0d, landmarks %0d, empty markers %0d, over six settings",
                 sent, landmarks, markers);
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
+incdir+design
design/tlt_pkg.sv
design/tentative_landmark_table.sv
design/tlt_checker.sv
dv/tentative_landmark_table_chk.sv
dv/tentative_landmark_table_tb.sv
